FILE: hdl/hsrt_pkg.sv
// ============================================================================
// hsrt_pkg: shared types and constants for the k-sorted stream sorter
// Sizes, payload structs, heap memory command and sequencer states.
// ============================================================================
package hsrt_pkg;

    localparam int HEAP_DEPTH = 16;
    localparam int IDX_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int KID_W      = IDX_W + 2;
    localparam int VAL_W      = 32;
    localparam int K_W        = 4;
    localparam int CMP_W      = (CNT_W > K_W) ? CNT_W : K_W;

    localparam logic [K_W-1:0] WINDOW_K_RESET = K_W'(3);

    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic signed [VAL_W-1:0] val_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    end_of_stream;
    } item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] sorted_value;
        logic                    last_out;
    } result_t;

    typedef struct packed {
        logic we;
        idx_t waddr;
        val_t wdata;
        logic re0;
        idx_t raddr0;
        logic re1;
        idx_t raddr1;
    } ram_cmd_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } emit_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_FULL_RD,
        ST_FULL_CMP,
        ST_DOWN_RD,
        ST_DOWN_LR,
        ST_DOWN_CMP,
        ST_CHECK,
        ST_POP_RD,
        ST_POP_EMIT
    } seq_state_t;

endpackage

FILE: hdl/k_sorted_stream_sorter.sv
// ============================================================================
// k_sorted_stream_sorter: sorter for nearly sorted streams
// Min-heap over HEAP_DEPTH entries; emits values in ascending order.
// ============================================================================
// Usage:
//   item channel (item_valid/item_ready/item) takes one value per transaction.
//   While the heap holds more than window_k values, each item drives pops of
//   the minimum onto the result channel (result_valid/result_ready/result).
//   An item with end_of_stream set drains the whole heap; the final result
//   of that drain carries last_out.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes window_k; cfg_ready is
//   always high. Write it only while the block is idle.
// Sequence:
//   One item at a time: an accept step, the insert (a replace-top when the
//   heap is full), a check step, then the same for each pop. An insert reads
//   the parent and compares once per level the value climbs, then writes
//   at the root or where it stops. A pop reads root and last entry, emits,
//   then per level reads the children, picks the smaller and compares; it
//   ends with a write at a leaf or after a failed compare.
// Reset: heap count clears to zero and window_k returns to 3; heap contents
//   are not cleared, only written entries are ever read.
// Stall: one output register holds a result; while it is not taken the
//   sequencer waits at its emit step and item_ready stays low.
// ============================================================================
module k_sorted_stream_sorter (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [hsrt_pkg::K_W-1:0] cfg_data,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  hsrt_pkg::item_t          item,
    output logic                     result_valid,
    input  logic                     result_ready,
    output hsrt_pkg::result_t        result
);
    import hsrt_pkg::*;

    logic [K_W-1:0] window_k_reg;
    logic           result_valid_reg;
    result_t        result_reg;

    ram_cmd_t ram_cmd;
    val_t     rd0;
    val_t     rd1;
    emit_t    seq_emit;
    logic     emit_ok;
    cnt_t     heap_count;

    // configuration: always ready, takes effect at the next item
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_k_reg <= WINDOW_K_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            window_k_reg <= cfg_data;
        end
    end

    hsrt_heap_ram u_ram (
        .clk (clk),
        .cmd (ram_cmd),
        .rd0 (rd0),
        .rd1 (rd1)
    );

    hsrt_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .window_k   (window_k_reg),
        .ram_cmd    (ram_cmd),
        .rd0        (rd0),
        .rd1        (rd1),
        .emit       (seq_emit),
        .emit_ok    (emit_ok),
        .heap_count (heap_count)
    );

    // Output register: load when empty or being drained this cycle,
    // otherwise hold the sequencer at its emit step.
    assign emit_ok = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (seq_emit.valid && emit_ok)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_emit.valid && emit_ok)
        begin
            result_reg <= seq_emit.res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        heap_count <= CNT_W'(HEAP_DEPTH))
        else $error("heap count exceeds heap depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item channel ready right after a transaction");

    a_emit_held: assert property (@(posedge clk) disable iff (!rst_n)
        seq_emit.valid && !emit_ok |=> seq_emit.valid)
        else $error("stalled result dropped by sequencer");

    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        seq_emit.valid && emit_ok && seq_emit.res.last_out |=> heap_count == '0)
        else $error("heap not empty after final result");

endmodule

FILE: hdl/hsrt_heap_ram.sv
// ============================================================================
// hsrt_heap_ram: heap storage
// One write port and two read ports; read data is registered and holds
// while its port is not enabled.
// ============================================================================
module hsrt_heap_ram (
    input  logic              clk,
    input  hsrt_pkg::ram_cmd_t cmd,
    output hsrt_pkg::val_t    rd0,
    output hsrt_pkg::val_t    rd1
);
    import hsrt_pkg::*;

    val_t mem [HEAP_DEPTH];
    val_t rd0_reg;
    val_t rd1_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.waddr] <= cmd.wdata;
        end
        if (cmd.re0)
        begin
            rd0_reg <= mem[cmd.raddr0];
        end
        if (cmd.re1)
        begin
            rd1_reg <= mem[cmd.raddr1];
        end
    end

    assign rd0 = rd0_reg;
    assign rd1 = rd1_reg;

endmodule

FILE: hdl/hsrt_seq.sv
// ============================================================================
// hsrt_seq: heap sequencer
// Runs insert, replace-top and pop with sift passes over the heap memory,
// using one shared signed comparator.
// ============================================================================
module hsrt_seq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  hsrt_pkg::item_t           item,
    input  logic [hsrt_pkg::K_W-1:0]  window_k,
    output hsrt_pkg::ram_cmd_t        ram_cmd,
    input  hsrt_pkg::val_t            rd0,
    input  hsrt_pkg::val_t            rd1,
    output hsrt_pkg::emit_t           emit,
    input  logic                      emit_ok,
    output hsrt_pkg::cnt_t            heap_count
);
    import hsrt_pkg::*;

    seq_state_t state_reg, state_next;
    cnt_t       count_reg, count_next;
    idx_t       hole_reg, hole_next;
    logic       eos_reg, eos_next;
    val_t       cur_reg, cur_next;
    val_t       best_reg, best_next;
    idx_t       best_idx_reg, best_idx_next;

    idx_t             parent;
    idx_t             last_idx;
    logic [KID_W-1:0] kid_l;
    logic [KID_W-1:0] kid_r;
    logic             l_ok;
    logic             r_ok;
    logic             full;
    logic             need_pop;
    val_t             cmp_a;
    val_t             cmp_b;
    logic             cmp_lt;

    assign parent   = idx_t'((hole_reg - 1'b1) >> 1);
    assign last_idx = idx_t'(count_reg - 1'b1);
    assign kid_l    = {1'b0, hole_reg, 1'b1};
    assign kid_r    = kid_l + 1'b1;
    assign l_ok     = kid_l < KID_W'(count_reg);
    assign r_ok     = kid_r < KID_W'(count_reg);
    assign full     = count_reg == CNT_W'(HEAP_DEPTH);
    assign need_pop = (count_reg != '0)
                      && (eos_reg || (CMP_W'(count_reg) > CMP_W'(window_k)));

    // shared compare unit
    assign cmp_lt = cmp_a < cmp_b;

    assign heap_count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            hole_reg  <= '0;
            eos_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            hole_reg  <= hole_next;
            eos_reg   <= eos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (item_valid) state_next = full ? ST_FULL_RD : ST_UP_RD;
            ST_UP_RD:    state_next = (hole_reg == '0) ? ST_CHECK : ST_UP_CMP;
            ST_UP_CMP:   state_next = cmp_lt ? ST_UP_RD : ST_CHECK;
            ST_FULL_RD:  state_next = ST_FULL_CMP;
            ST_FULL_CMP: if (emit_ok) state_next = cmp_lt ? ST_DOWN_RD : ST_CHECK;
            ST_DOWN_RD:  state_next = l_ok ? ST_DOWN_LR : ST_CHECK;
            ST_DOWN_LR:  state_next = ST_DOWN_CMP;
            ST_DOWN_CMP: state_next = cmp_lt ? ST_DOWN_RD : ST_CHECK;
            ST_CHECK:    state_next = need_pop ? ST_POP_RD : ST_IDLE;
            ST_POP_RD:   state_next = ST_POP_EMIT;
            ST_POP_EMIT: if (emit_ok) state_next = ST_DOWN_RD;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs: handshake, memory command, emit, comparator operands
    always_comb
    begin
        item_ready = 1'b0;
        ram_cmd    = '0;
        emit       = '0;
        cmp_a      = cur_reg;
        cmp_b      = rd0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
            end
            ST_UP_RD:
            begin
                if (hole_reg == '0)
                begin
                    ram_cmd.we    = 1'b1;
                    ram_cmd.waddr = '0;
                    ram_cmd.wdata = cur_reg;
                end
                else
                begin
                    ram_cmd.re0    = 1'b1;
                    ram_cmd.raddr0 = parent;
                end
            end
            ST_UP_CMP:
            begin
                ram_cmd.we    = 1'b1;
                ram_cmd.waddr = hole_reg;
                ram_cmd.wdata = cmp_lt ? rd0 : cur_reg;
            end
            ST_FULL_RD:
            begin
                ram_cmd.re0    = 1'b1;
                ram_cmd.raddr0 = '0;
            end
            ST_FULL_CMP:
            begin
                cmp_a                 = rd0;
                cmp_b                 = cur_reg;
                emit.valid            = 1'b1;
                emit.res.sorted_value = cmp_lt ? rd0 : cur_reg;
                emit.res.last_out     = 1'b0;
            end
            ST_DOWN_RD:
            begin
                if (!l_ok)
                begin
                    ram_cmd.we    = 1'b1;
                    ram_cmd.waddr = hole_reg;
                    ram_cmd.wdata = cur_reg;
                end
                else
                begin
                    ram_cmd.re0    = 1'b1;
                    ram_cmd.raddr0 = idx_t'(kid_l);
                    ram_cmd.re1    = r_ok;
                    ram_cmd.raddr1 = idx_t'(kid_r);
                end
            end
            ST_DOWN_LR:
            begin
                cmp_a = rd1;
                cmp_b = rd0;
            end
            ST_DOWN_CMP:
            begin
                cmp_a         = best_reg;
                cmp_b         = cur_reg;
                ram_cmd.we    = 1'b1;
                ram_cmd.waddr = hole_reg;
                ram_cmd.wdata = cmp_lt ? best_reg : cur_reg;
            end
            ST_POP_RD:
            begin
                ram_cmd.re0    = 1'b1;
                ram_cmd.raddr0 = '0;
                ram_cmd.re1    = 1'b1;
                ram_cmd.raddr1 = last_idx;
            end
            ST_POP_EMIT:
            begin
                emit.valid            = 1'b1;
                emit.res.sorted_value = rd0;
                emit.res.last_out     = eos_reg && (count_reg == CNT_W'(1));
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        count_next    = count_reg;
        hole_next     = hole_reg;
        eos_next      = eos_reg;
        cur_next      = cur_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cur_next = item.value;
                    eos_next = item.end_of_stream;
                    if (full)
                    begin
                        hole_next = '0;
                    end
                    else
                    begin
                        hole_next  = idx_t'(count_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_UP_CMP:
            begin
                if (cmp_lt)
                begin
                    hole_next = parent;
                end
            end
            ST_FULL_CMP:
            begin
                if (emit_ok && cmp_lt)
                begin
                    hole_next = '0;
                end
            end
            ST_DOWN_LR:
            begin
                if (r_ok && cmp_lt)
                begin
                    best_next     = rd1;
                    best_idx_next = idx_t'(kid_r);
                end
                else
                begin
                    best_next     = rd0;
                    best_idx_next = idx_t'(kid_l);
                end
            end
            ST_DOWN_CMP:
            begin
                if (cmp_lt)
                begin
                    hole_next = best_idx_reg;
                end
            end
            ST_POP_EMIT:
            begin
                if (emit_ok)
                begin
                    count_next = count_reg - 1'b1;
                    cur_next   = rd1;
                    hole_next  = '0;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

endmodule
